[hdl/bmr_pkg.sv]
// Shared types and constants for the boot mouse report decoder.
package bmr_pkg;

   localparam int unsigned MASK_W = 7;
   localparam logic [2:0] BUTTON_MASK = 3'h7;
   localparam logic [7:0] MIN_LENGTH = 8'd3;
   localparam logic [7:0] WHEEL_LENGTH = 8'd4;

   typedef enum logic [2:0] {
      KIND_LEFT   = 3'd0,
      KIND_RIGHT  = 3'd1,
      KIND_MIDDLE = 3'd2,
      KIND_X      = 3'd3,
      KIND_Y      = 3'd4,
      KIND_WHEEL  = 3'd5,
      KIND_NONE   = 3'd6
   } kind_type;

   // One decoded report: bit k of mask requests an event of kind k.
   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [2:0]        buttons;
      logic [7:0]        x_delta;
      logic [7:0]        y_delta;
      logic [7:0]        wheel_delta;
      logic [31:0]       count;
   } entry_type;

endpackage

[hdl/bmr_front.sv]
// Front end: accepts report slots, filters and classifies them into event masks.
module bmr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         mouse_code,
   input  logic               push,
   input  logic [7:0]         slot_code,
   input  logic [7:0]         report_length,
   input  logic [7:0]         button_byte,
   input  logic [7:0]         x_delta,
   input  logic [7:0]         y_delta,
   input  logic [7:0]         wheel_delta,
   input  logic               q_full,
   output logic               q_push,
   output bmr_pkg::entry_type q_entry
);
   import bmr_pkg::*;

   logic [2:0]  prev_buttons_ff, prev_buttons_in;
   logic [31:0] malformed_ff, malformed_in;
   logic        accept, is_mouse, is_short;
   logic [2:0]  buttons, changed;
   logic        x_ev, y_ev, w_ev;

   assign accept   = push && !q_full;
   assign is_mouse = slot_code == mouse_code;
   assign is_short = report_length < MIN_LENGTH;
   assign buttons  = button_byte[2:0] & BUTTON_MASK;
   assign changed  = buttons ^ prev_buttons_ff;
   assign x_ev     = x_delta != 8'd0;
   assign y_ev     = y_delta != 8'd0;
   assign w_ev     = (report_length >= WHEEL_LENGTH) && (wheel_delta != 8'd0);

   assign q_push = accept && is_mouse && !is_short;

   always_comb begin
      q_entry.mask        = {1'b0, w_ev, y_ev, x_ev, changed};
      q_entry.mask[KIND_NONE] = !(|{w_ev, y_ev, x_ev, changed});
      q_entry.buttons     = buttons;
      q_entry.x_delta     = x_delta;
      q_entry.y_delta     = y_delta;
      q_entry.wheel_delta = wheel_delta;
      q_entry.count       = malformed_ff;
   end

   always_comb begin
      prev_buttons_in = prev_buttons_ff;
      malformed_in    = malformed_ff;
      if (accept && is_mouse) begin
         if (is_short) begin
            if (malformed_ff != 32'hFFFF_FFFF) begin
               malformed_in = malformed_ff + 32'd1;
            end
         end else begin
            prev_buttons_in = buttons;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= 3'd0;
         malformed_ff    <= 32'd0;
      end else begin
         prev_buttons_ff <= prev_buttons_in;
         malformed_ff    <= malformed_in;
      end
   end

endmodule

[hdl/bmr_queue.sv]
// Small queue of decoded reports between front and back end.
module bmr_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bmr_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output bmr_pkg::entry_type head
);
   import bmr_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == CNT_W'(0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/bmr_back.sv]
// Back end: expands one decoded report into events, one event per cycle while the output register is free.
module bmr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  bmr_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output logic [2:0]         event_kind,
   output logic [7:0]         event_value,
   output logic               last_of_report,
   output logic [31:0]        malformed_count
);
   import bmr_pkg::*;

   logic        work_valid_ff, work_valid_in;
   entry_type   work_ff, work_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  kind_ff;
   logic [7:0]  value_ff;
   logic        last_ff;
   logic [31:0] count_ff;

   logic              out_free, fire, is_last;
   logic [2:0]        sel;
   logic [7:0]        sel_value;
   logic [MASK_W-1:0] rest;

   // Lowest pending event kind goes first.
   always_comb begin
      sel = 3'(KIND_NONE);
      for (int k = MASK_W - 1; k >= 0; k--) begin
         if (work_ff.mask[k]) begin
            sel = 3'(k);
         end
      end
   end

   always_comb begin
      unique case (sel) inside
         KIND_LEFT, KIND_RIGHT, KIND_MIDDLE: sel_value = {7'd0, work_ff.buttons[sel[1:0]]};
         KIND_X:                             sel_value = work_ff.x_delta;
         KIND_Y:                             sel_value = work_ff.y_delta;
         KIND_WHEEL:                         sel_value = work_ff.wheel_delta;
         default:                            sel_value = 8'd0;
      endcase
   end

   assign rest     = work_ff.mask & ~(MASK_W'(1) << sel);
   assign is_last  = rest == '0;
   assign out_free = !out_valid_ff || pop;
   assign fire     = work_valid_ff && out_free;
   assign q_pop    = !q_empty && (!work_valid_ff || (fire && is_last));

   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      if (q_pop) begin
         work_valid_in = 1'b1;
         work_in       = q_head;
      end else if (fire) begin
         work_in.mask = rest;
         if (is_last) begin
            work_valid_in = 1'b0;
         end
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (fire) begin
         kind_ff  <= sel;
         value_ff <= sel_value;
         last_ff  <= is_last;
         count_ff <= work_ff.count;
      end
   end

   assign empty           = !out_valid_ff;
   assign event_kind      = kind_ff;
   assign event_value     = value_ff;
   assign last_of_report  = last_ff;
   assign malformed_count = count_ff;

endmodule

[hdl/boot_mouse_report_to_events.sv]
// Top level of the boot mouse report decoder: control register, front, queue, back.
//
//  channel   handshake          beat
//  -------   ----------------   ---------------------------------------------------
//  req       push / full        one report slot: type, length, four report bytes
//  rsp       empty / pop        one event: kind, value, last flag, malformed count
//  csr       psel/penable/...   mouse_slot_type at byte address 0, always ready
//
// A slot is taken in any cycle the queue has room; the front classifies it in that
// same cycle, so back-to-back beats flow at one per cycle.
// The back end emits one event per cycle from the head report while the output register is
// free; a report yields 1 to 6 events.
// The output register is refilled in the cycle it is popped, so a steady pop sees
// no bubbles; a stalled rsp side fills the queue and then raises full.
// Reset (synchronous) clears button history, malformed count, queue and output;
// mouse_slot_type returns to 1.
module boot_mouse_report_to_events #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_slot_type,
   input  logic [7:0]  req_report_length,
   input  logic [7:0]  req_button_byte,
   input  logic signed [7:0] req_x_delta,
   input  logic signed [7:0] req_y_delta,
   input  logic signed [7:0] req_wheel_delta,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_event_kind,
   output logic signed [7:0] rsp_event_value,
   output logic        rsp_last_of_report,
   output logic [31:0] rsp_malformed_count,
   // control register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bmr_pkg::*;

   localparam logic MOUSE_TYPE_REG = 1'b0;

   logic [7:0] mouse_slot_type_ff, mouse_slot_type_in;
   logic       reg_write;
   logic       q_push, q_pop, q_full, q_empty;
   entry_type  q_entry, q_head;
   logic [7:0] event_value;

   // Register file: one register, word index taken from paddr[2].
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      mouse_slot_type_in = mouse_slot_type_ff;
      if (reg_write && (paddr[2] == MOUSE_TYPE_REG)) begin
         mouse_slot_type_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_slot_type_ff <= 8'd1;
      end else begin
         mouse_slot_type_ff <= mouse_slot_type_in;
      end
   end

   assign prdata = (paddr[2] == MOUSE_TYPE_REG) ? {24'd0, mouse_slot_type_ff} : 32'd0;

   // Filter, count short reports and build the event mask.
   bmr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .mouse_code      (mouse_slot_type_ff),
      .push            (push),
      .slot_code       (req_slot_type),
      .report_length   (req_report_length),
      .button_byte     (req_button_byte),
      .x_delta         (req_x_delta),
      .y_delta         (req_y_delta),
      .wheel_delta     (req_wheel_delta),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   // Decouple slot intake from event output.
   bmr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   // Walk the mask, one event per beat.
   bmr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .event_kind      (rsp_event_kind),
      .event_value     (event_value),
      .last_of_report  (rsp_last_of_report),
      .malformed_count (rsp_malformed_count)
   );

   assign rsp_event_value = signed'(event_value);
   // Hold intake while the queue is full.
   assign full = q_full;

endmodule

[dv/boot_mouse_report_to_events_test.sv]
// Self-checking testbench for the boot mouse report decoder: directed and random reports.
`timescale 1ns / 1ps

module boot_mouse_report_to_events_test;
   import bmr_pkg::*;

   localparam logic [2:0] ADDR_MOUSE_TYPE = 3'd0;   // mouse_slot_type
   localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;   // no register here, writes vanish
   localparam logic [7:0] MOUSE_TYPE_RESET = 8'd1;
   localparam int LATENCY_SLACK = 16;
   localparam int CYCLE_LIMIT   = 200000;

   // One expected event beat on the rsp side.
   typedef struct {
      kind_type          kind;
      logic signed [7:0] value;
      logic              last;
      logic [31:0]       count;
   } mouse_event_type;

   // Tracks decoder state (button history, short report count, slot type) and
   // holds the events each accepted report should produce, oldest first.
   class event_tracker;
      logic [7:0]      slot_type_code;
      logic [2:0]      held_buttons;
      logic [31:0]     short_reports;
      mouse_event_type awaited_events[$];
      int              errors;

      function new();
         slot_type_code = MOUSE_TYPE_RESET;
         held_buttons   = '0;
         short_reports  = '0;
         errors         = 0;
      endfunction

      function void add_event(kind_type kind, logic signed [7:0] value);
         mouse_event_type ev;
         ev.kind  = kind;
         ev.value = value;
         ev.last  = 1'b0;
         ev.count = short_reports;
         awaited_events.push_back(ev);
      endfunction

      // Decode one accepted slot into its expected events.
      function void note_report(logic [7:0] slot_code, logic [7:0] length, logic [7:0] buttons,
                                logic signed [7:0] dx, logic signed [7:0] dy,
                                logic signed [7:0] dw);
         logic [2:0] now_buttons;
         logic [2:0] flipped;
         int         first;
         if (slot_code != slot_type_code) return;
         if (length < MIN_LENGTH) begin
            if (short_reports != '1) short_reports++;
            return;
         end
         now_buttons = buttons[2:0] & BUTTON_MASK;
         flipped     = now_buttons ^ held_buttons;
         first       = awaited_events.size();
         for (int b = 0; b < 3; b++) begin
            if (flipped[b]) add_event(kind_type'(b), {7'b0, now_buttons[b]});
         end
         held_buttons = now_buttons;
         if (dx != 0) add_event(KIND_X, dx);
         if (dy != 0) add_event(KIND_Y, dy);
         if (length >= WHEEL_LENGTH && dw != 0) add_event(KIND_WHEEL, dw);
         if (awaited_events.size() == first) add_event(KIND_NONE, 8'sd0);
         awaited_events[awaited_events.size() - 1].last = 1'b1;
      endfunction

      function void check_event(logic [2:0] kind, logic signed [7:0] value, logic last,
                                logic [31:0] count);
         mouse_event_type want;
         if (awaited_events.size() == 0) begin
            $error("unexpected event: kind %0d value %0d last %0d", kind, value, last);
            errors++;
            return;
         end
         want = awaited_events.pop_front();
         if (kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, kind);
            errors++;
         end
         if (value !== want.value) begin
            $error("event_value: expected %0d, got %0d", want.value, value);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_report: expected %0d, got %0d", want.last, last);
            errors++;
         end
         if (count !== want.count) begin
            $error("malformed_count: expected %0d, got %0d", want.count, count);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_events.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              push = 1'b0;
   logic              full;
   logic [7:0]        req_slot_type = '0;
   logic [7:0]        req_report_length = '0;
   logic [7:0]        req_button_byte = '0;
   logic signed [7:0] req_x_delta = '0;
   logic signed [7:0] req_y_delta = '0;
   logic signed [7:0] req_wheel_delta = '0;

   logic              empty;
   logic              pop = 1'b0;
   logic [2:0]        rsp_event_kind;
   logic signed [7:0] rsp_event_value;
   logic              rsp_last_of_report;
   logic [31:0]       rsp_malformed_count;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   event_tracker tracker = new();
   int  cycle_count = 0;
   // Calm stretches: while set, that side never idles.
   bit  send_calm = 1'b0;
   bit  take_calm = 1'b1;

   boot_mouse_report_to_events DUT (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_slot_type(req_slot_type), .req_report_length(req_report_length),
      .req_button_byte(req_button_byte), .req_x_delta(req_x_delta),
      .req_y_delta(req_y_delta), .req_wheel_delta(req_wheel_delta),
      .empty(empty), .pop(pop),
      .rsp_event_kind(rsp_event_kind), .rsp_event_value(rsp_event_value),
      .rsp_last_of_report(rsp_last_of_report), .rsp_malformed_count(rsp_malformed_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("boot_mouse_report_to_events regression: fail");
         $finish;
      end
   end

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   // Present one slot and hold it until the decoder takes it. Push stays high on
   // return so a following beat with no gap flows back to back.
   task automatic send_report(input logic [7:0] slot_code, input logic [7:0] length,
                              input logic [7:0] buttons, input logic signed [7:0] dx,
                              input logic signed [7:0] dy, input logic signed [7:0] dw);
      int gap;
      if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push              <= 1'b1;
      req_slot_type     <= slot_code;
      req_report_length <= length;
      req_button_byte   <= buttons;
      req_x_delta       <= dx;
      req_y_delta       <= dy;
      req_wheel_delta   <= dw;
      do @(posedge clock); while (full);
      tracker.note_report(slot_code, length, buttons, dx, dy, dw);
   endtask

   // Drop push and hold off until every awaited event has been popped.
   task automatic wait_drained();
      push <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // Write a register once the decoder is idle, then read mouse_slot_type back.
   task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
      logic [31:0] got;
      wait_drained();
      // Short and foreign slots leave no event behind; give them time to retire.
      repeat (LATENCY_SLACK) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_MOUSE_TYPE) tracker.slot_type_code = data[7:0];
      // Go straight into the read-back setup phase.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_MOUSE_TYPE;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== {24'b0, tracker.slot_type_code}) begin
         $error("mouse_slot_type: expected %0d, got %0d", tracker.slot_type_code, got);
         tracker.errors++;
      end
   endtask

   // Random reports: mostly well-formed mouse slots, some short ones and some noise.
   task automatic run_random(input int count);
      int         roll;
      logic [7:0] slot_code;
      logic [7:0] length;
      logic [7:0] buttons;
      logic [7:0] motion [3];
      for (int n = 0; n < count; n++) begin
         // Let the queue run dry now and then.
         if (n > 0 && n % 40 == 0) wait_drained();
         roll      = $urandom_range(0, 99);
         slot_code = (roll < 12) ? 8'($urandom_range(0, 255)) : tracker.slot_type_code;
         roll      = $urandom_range(0, 99);
         if (roll < 8)       length = 8'($urandom_range(0, 2));
         else if (roll < 45) length = 8'd3;
         else if (roll < 85) length = 8'd4;
         else                length = 8'($urandom_range(5, 255));
         buttons = 8'($urandom_range(0, 255));
         // Keep the buttons unchanged often, so motion-only and empty reports appear.
         if ($urandom_range(0, 2) == 0) buttons[2:0] = tracker.held_buttons;
         foreach (motion[k]) motion[k] = ($urandom_range(0, 99) < 35) ? 8'd0
                                                                        : 8'($urandom_range(0, 255));
         send_report(slot_code, length, buttons, motion[0], motion[1], motion[2]);
      end
   endtask

   // Result side: pop beats with random stalls and check each one.
   task automatic take_events();
      int gap;
      forever begin
         if ($urandom_range(0, 19) == 0) take_calm = !take_calm;
         gap = draw_gap(take_calm);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         tracker.check_event(rsp_event_kind, rsp_event_value, rsp_last_of_report,
                             rsp_malformed_count);
      end
   endtask

   initial begin
      logic [7:0] mt;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      fork
         take_events();
      join_none

      // Directed part under the reset slot type.
      mt = tracker.slot_type_code;
      send_report(8'h00, 8'd4, 8'h07, 8'sd5, 8'sd5, 8'sd5);       // foreign type, dropped
      send_report(8'hFE, 8'd4, 8'h07, 8'sd5, 8'sd5, 8'sd5);       // foreign type, dropped
      send_report(mt, 8'd0, 8'h07, 8'sd1, 8'sd1, 8'sd1);          // short reports, counted
      send_report(mt, 8'd1, 8'h07, 8'sd1, 8'sd1, 8'sd1);
      send_report(mt, 8'd2, 8'h07, 8'sd1, 8'sd1, 8'sd1);
      send_report(mt, 8'd3, 8'h00, 8'sd0, 8'sd0, 8'sd7);          // wheel ignored: no-event
      send_report(mt, 8'd4, 8'h01, 8'sd0, 8'sd0, 8'sd0);          // left press
      send_report(mt, 8'd4, 8'h07, 8'sd0, 8'sd0, 8'sd0);          // right, middle press
      send_report(mt, 8'd4, 8'hF8, 8'sd0, 8'sd0, 8'sd0);          // upper bits only: release all
      send_report(mt, 8'd4, 8'h00, 8'sh7F, 8'sd0, 8'sd0);
      send_report(mt, 8'd4, 8'h00, 8'sh80, 8'sh7F, 8'sd0);
      send_report(mt, 8'd4, 8'h00, 8'sd0, 8'sh80, 8'sh7F);
      send_report(mt, 8'd4, 8'h00, 8'sd0, 8'sd0, 8'sh80);
      send_report(mt, 8'hFF, 8'h07, -8'sd1, 8'sd1, -8'sd1);       // six events, long length
      send_report(mt, 8'd5, 8'hFF, 8'sd0, 8'sd0, 8'sd1);          // wheel only
      send_report(mt, 8'd3, 8'h02, 8'sd1, -8'sd1, 8'sd5);         // left, middle release, x and y; wheel ignored
      send_report(mt, 8'd4, 8'h02, 8'sd0, 8'sd0, 8'sd0);          // nothing changed
      send_report(mt, 8'hFF, 8'h55, 8'sh55, 8'shAA, 8'sh2A);
      send_report(mt, 8'd2, 8'hAA, 8'shAA, 8'sh55, 8'shD5);       // short again

      // Walk the slot type through its extremes and back.
      set_register(ADDR_MOUSE_TYPE, 32'h0000_0000);
      run_random(40);
      set_register(ADDR_MOUSE_TYPE, 32'hFFFF_FFFF);
      run_random(40);
      set_register(ADDR_UNMAPPED, $urandom());
      run_random(10);
      set_register(ADDR_MOUSE_TYPE, $urandom());
      run_random(40);
      set_register(ADDR_MOUSE_TYPE, {24'b0, MOUSE_TYPE_RESET});
      run_random(20);

      // Drain, then watch for stray beats before the verdict.
      wait_drained();
      repeat (LATENCY_SLACK) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("boot_mouse_report_to_events regression: pass");
      else
         $display("boot_mouse_report_to_events regression: fail");
      $finish;
   end

endmodule
